>>> hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

>>> hdl/double_ended_queue_top.sv
// Top level of the double-ended queue: ring pointers, RAM access and result register.
//
// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// RAM entries, addressed by a head index and an entry count. Each input word
// carries one operation (push front, push rear, pop front, pop rear) and
// produces exactly one result word with the popped value, a status code and
// the occupancy after the operation. A push, a rejected push on a full queue
// and a pop on an empty queue load the result register directly, so such words
// may follow one another in every cycle while results are taken. A pop that
// returns a value waits for the registered ring RAM read; the input is held off
// for the cycle in which the read data returns. A new input word is taken only
// while the result register is empty or its word leaves in the same cycle.
// Ring entries hold no reset value and there is no clearing pass after reset.
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_mode,
    input  logic signed [deq_pkg::DATA_W-1:0]  i_data_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]  o_value_out,
    output logic [1:0]                         o_status,
    output logic [$clog2(DEPTH+1)-1:0]         o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0]                r_head;
    logic [AW-1:0]                n_head;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_rd_pend;
    logic                         n_rd_pend;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [deq_pkg::DATA_W-1:0]   r_value;
    logic [deq_pkg::DATA_W-1:0]   n_value;
    deq_pkg::t_status             r_status;
    deq_pkg::t_status             n_status;
    logic [CW-1:0]                r_occ;
    logic [CW-1:0]                n_occ;

    logic                         w_acc;
    logic                         w_full;
    logic                         w_empty;
    logic [AW-1:0]                w_head_dec;
    logic [AW-1:0]                w_head_inc;
    logic [SW-1:0]                w_rear_sum;
    logic [AW-1:0]                w_rear_wr;
    logic [AW-1:0]                w_rear_rd;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic [deq_pkg::DATA_W-1:0]   w_rdata;

    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[AW-1:0];
    endfunction

    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_rear_sum = SW'(r_head) + SW'(r_count);
    assign w_rear_wr  = f_wrap(w_rear_sum);
    assign w_rear_rd  = f_wrap(w_rear_sum - 1'b1);

    assign o_in_ready = !r_rd_pend && (!r_out_valid || i_out_ready);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;
        n_status    = r_status;
        n_occ       = r_occ;
        w_we        = 1'b0;
        w_waddr     = w_rear_wr;
        w_re        = 1'b0;
        w_raddr     = r_head;
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_value     = w_rdata;
        end
        if (w_acc) begin
            n_value  = '0;
            n_status = deq_pkg::ST_DONE;
            case (deq_pkg::t_mode'(i_mode))
                deq_pkg::MODE_PUSH_FRONT: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_head_dec;
                        n_head  = w_head_dec;
                        n_count = r_count + 1'b1;
                    end
                end
                deq_pkg::MODE_PUSH_REAR: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_rear_wr;
                        n_count = r_count + 1'b1;
                    end
                end
                deq_pkg::MODE_POP_FRONT: begin
                    if (w_empty) begin
                        n_out_valid = 1'b1;
                        n_value     = deq_pkg::EMPTY_VALUE;
                        n_status    = deq_pkg::ST_EMPTY;
                    end else begin
                        w_re      = 1'b1;
                        w_raddr   = r_head;
                        n_head    = w_head_inc;
                        n_count   = r_count - 1'b1;
                        n_rd_pend = 1'b1;
                    end
                end
                deq_pkg::MODE_POP_REAR: begin
                    if (w_empty) begin
                        n_out_valid = 1'b1;
                        n_value     = deq_pkg::EMPTY_VALUE;
                        n_status    = deq_pkg::ST_EMPTY;
                    end else begin
                        w_re      = 1'b1;
                        w_raddr   = w_rear_rd;
                        n_count   = r_count - 1'b1;
                        n_rd_pend = 1'b1;
                    end
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
            n_occ = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_value  <= n_value;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_in),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(DEPTH - 1))
        else $error("head index outside ring");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> (r_out_valid && r_status == deq_pkg::ST_DONE))
        else $error("pop read did not load the result register");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_mode[1] && w_full) |=> ($stable(r_count) && $stable(r_head)))
        else $error("rejected push changed the pointers");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode[1] && w_empty) |=> (!r_rd_pend && r_count == '0))
        else $error("pop on empty queue changed the state");

endmodule

>>> hdl/deq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/double_ended_queue_top_tb.sv
// Testbench for double_ended_queue_top: random push/pop traffic checked against a deque predictor.

typedef struct packed {
    logic [31:0]      value;
    deq_pkg::t_status status;
    logic [4:0]       occupancy;
} t_deq_result;

class deque_scoreboard;
    localparam int DEPTH = 16;

    logic [31:0]  ring [DEPTH];
    logic [3:0]   head;
    logic [4:0]   count;
    t_deq_result  pending_results[$];
    int unsigned  failures;

    function new();
        head = '0;
        count = '0;
        failures = 0;
    endfunction

    function void note_word(deq_pkg::t_mode op, logic [31:0] word);
        t_deq_result res;
        logic [3:0]  idx;
        res.value = '0;
        res.status = deq_pkg::ST_DONE;
        case (op)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
                if (count == DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else if (op == deq_pkg::MODE_PUSH_FRONT) begin
                    head = head - 4'd1;
                    ring[head] = word;
                    count++;
                end else begin
                    idx = head + count[3:0];
                    ring[idx] = word;
                    count++;
                end
            end
            default: begin
                if (count == 0) begin
                    res.value = deq_pkg::EMPTY_VALUE;
                    res.status = deq_pkg::ST_EMPTY;
                end else if (op == deq_pkg::MODE_POP_FRONT) begin
                    res.value = ring[head];
                    head = head + 4'd1;
                    count--;
                end else begin
                    idx = head + count[3:0] - 4'd1;
                    res.value = ring[idx];
                    count--;
                end
            end
        endcase
        res.occupancy = count;
        pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] status, logic [4:0] occupancy);
        t_deq_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual value %0h status %0d",
                     $time, value, status);
            failures++;
        end else begin
            want = pending_results.pop_front();
            compare_field("value_out", want.value, value);
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        end
    endfunction
endclass

module double_ended_queue_top_tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 750;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [1:0]                        i_mode;
    logic signed [deq_pkg::DATA_W-1:0] i_data_in;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [deq_pkg::DATA_W-1:0] o_value_out;
    logic [1:0]                        o_status;
    logic [OCC_W-1:0]                  o_occupancy;

    deque_scoreboard sb;
    int              idle_cycles;
    int              burst_left;

    double_ended_queue_top #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_value_out, o_status, o_occupancy);
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_word(deq_pkg::t_mode'(i_mode), i_data_in);
        end
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int rx_style;
        int rx_span;
        i_out_ready = 1'b0;
        rx_style = 0;
        rx_span = 0;
        forever begin
            @(negedge i_clk);
            if (rx_span == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_span = $urandom_range(10, 60);
            end
            rx_span--;
            case (rx_style)
                0: i_out_ready = 1'b1;
                1: i_out_ready = 1'($urandom_range(0, 1));
                2: i_out_ready = (rx_span % 4) != 0;
                default: i_out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(input deq_pkg::t_mode op, input logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 8);
        end
        i_in_valid = 1'b1;
        i_mode = op;
        i_data_in = word;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic deq_pkg::t_mode pick_op(int push_pct);
        if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? deq_pkg::MODE_POP_REAR : deq_pkg::MODE_POP_FRONT;
    endfunction

    initial begin
        int sent;
        int span;
        int push_pct;
        sb = new();
        idle_cycles = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = deq_pkg::MODE_PUSH_FRONT;
        i_data_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(deq_pkg::MODE_POP_FRONT, 32'h1234_5678);
        send_word(deq_pkg::MODE_POP_REAR, 32'hFFFF_FFFF);
        send_word(deq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(deq_pkg::MODE_PUSH_REAR, 32'h8000_0000);
        send_word(deq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(deq_pkg::MODE_PUSH_REAR, 32'h0000_0000);
        send_word(deq_pkg::MODE_POP_REAR, 32'h0);
        send_word(deq_pkg::MODE_POP_FRONT, 32'h0);
        send_word(deq_pkg::MODE_POP_REAR, 32'h0);
        send_word(deq_pkg::MODE_POP_FRONT, 32'h0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_word((i % 2) ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT,
                      pick_word());
        end
        send_word(deq_pkg::MODE_PUSH_FRONT, 32'hA5A5_A5A5);
        send_word(deq_pkg::MODE_PUSH_REAR, 32'h5A5A_5A5A);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            span = $urandom_range(20, 60);
            case ($urandom_range(0, 4))
                0: push_pct = 10;
                1: push_pct = 30;
                2: push_pct = 50;
                3: push_pct = 70;
                default: push_pct = 90;
            endcase
            for (int i = 0; i < span && sent < RANDOM_WORDS; i++) begin
                send_word(pick_op(push_pct), pick_word());
                sent++;
            end
        end

        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue_top.sv
tb/double_ended_queue_top_tb.sv
